### rtl/pnz_pkg.sv
// Shared constants, types and functions of the 2D gradient noise evaluator.
package pnz_pkg;

  // Number formats.
  localparam int COORD_FRAC_BITS = 16;
  localparam int ANGLE_BITS      = 10;
  localparam int OUT_FRAC_BITS   = 14;
  localparam int HASH_W          = 32;
  localparam int GRAD_W          = 16;
  localparam int OFS_W           = COORD_FRAC_BITS + 2;
  localparam int DOT_W           = 20;
  localparam int WGT_W           = 18;
  localparam int OUT_W           = 16;
  localparam int CFG_IDX_W       = 2;
  localparam int QUAD_BITS       = ANGLE_BITS - 2;
  localparam int GRAD_DEPTH      = 1 << QUAD_BITS;

  // Reset values of the hash multipliers.
  localparam logic [HASH_W-1:0] MULT_A_RESET = 32'd3284157443;
  localparam logic [HASH_W-1:0] MULT_B_RESET = 32'd1911520717;
  localparam logic [HASH_W-1:0] MULT_C_RESET = 32'd2048419325;

  // Rotation constants, evaluated at elaboration only.
  localparam int    CORDIC_STEPS = 16;
  localparam longint CORDIC_GAIN = 64'd652032874;
  localparam longint ARC_TBL [CORDIC_STEPS] = '{
    536870912, 316933405, 167458907, 85004756, 42667331, 21354465,
    10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef logic [ANGLE_BITS-1:0]       angle_t;
  typedef logic signed [GRAD_W-1:0]    grad_t;
  typedef logic signed [OFS_W-1:0]     ofs_t;
  typedef logic signed [DOT_W-1:0]     dot_t;
  typedef logic signed [WGT_W-1:0]     wgt_t;
  typedef logic [COORD_FRAC_BITS-1:0]  frac_t;
  typedef logic [GRAD_DEPTH-1:0][2*GRAD_W-1:0] grad_tbl_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MULT_A = 2'd0,
    CFG_MULT_B = 2'd1,
    CFG_MULT_C = 2'd2
  } cfg_idx_e;

  // Gradient quadrants.
  typedef enum logic [1:0] {
    QUAD_0 = 2'd0,
    QUAD_1 = 2'd1,
    QUAD_2 = 2'd2,
    QUAD_3 = 2'd3
  } quad_e;

  // Swap the two 16-bit halves of a word.
  function automatic logic [HASH_W-1:0] rot16(input logic [HASH_W-1:0] v);
    return {v[15:0], v[31:16]};
  endfunction

  // Clamp a rounded rotation result to the unit range in Q14.
  function automatic longint clamp_unit(input longint v);
    longint r;
    r = v;
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  // Cosine and sine in Q14 of an angle within the first quadrant.
  function automatic logic [2*GRAD_W-1:0] cordic_cs(input int unsigned r);
    longint z, cx, cy, nx, ny, c, s;
    z  = longint'(r) << (32 - ANGLE_BITS);
    cx = CORDIC_GAIN;
    cy = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = cx - (cy >>> i);
        ny = cy + (cx >>> i);
        z  = z - ARC_TBL[i];
      end else begin
        nx = cx + (cy >>> i);
        ny = cy - (cx >>> i);
        z  = z + ARC_TBL[i];
      end
      cx = nx;
      cy = ny;
    end
    c = clamp_unit((cx + 32768) >>> 16);
    s = clamp_unit((cy + 32768) >>> 16);
    return {c[GRAD_W-1:0], s[GRAD_W-1:0]};
  endfunction

  // Full quadrant table of gradient components, built at elaboration.
  function automatic grad_tbl_t build_grad_tbl();
    grad_tbl_t t;
    for (int k = 0; k < GRAD_DEPTH; k++) begin
      t[k] = cordic_cs(k);
    end
    return t;
  endfunction

  localparam grad_tbl_t GRAD_TBL = build_grad_tbl();

  // Bring a coordinate fraction to Q16.
  function automatic logic [15:0] frac_to_q16(input frac_t f);
    logic [47:0] w;
    w = 48'(f);
    if (COORD_FRAC_BITS >= 16) w = w >> (COORD_FRAC_BITS - 16);
    else w = w << (16 - COORD_FRAC_BITS);
    return w[15:0];
  endfunction

endpackage

### rtl/pnz_in_if.sv
// Input channel carrying one sample point per item.
interface pnz_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

### rtl/pnz_out_if.sv
// Output channel carrying one noise value per item.
interface pnz_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink   (input valid, input noise_value, output ready);
endinterface

### rtl/pnz_hash.sv
// Three-stage corner hash pipeline producing one angle per lattice corner.
module pnz_hash (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [pnz_pkg::HASH_W-1:0] mult_a_i,
  input  logic [pnz_pkg::HASH_W-1:0] mult_b_i,
  input  logic [pnz_pkg::HASH_W-1:0] mult_c_i,
  input  logic [pnz_pkg::HASH_W-1:0] ux_i [2],
  input  logic [pnz_pkg::HASH_W-1:0] uy_i [2],
  output pnz_pkg::angle_t           angle_o [4]
);
  import pnz_pkg::*;

  logic [HASH_W-1:0] a1_q [2];
  logic [HASH_W-1:0] uy1_q [2];
  logic [HASH_W-1:0] a2_q [4];
  logic [HASH_W-1:0] b2_q [4];
  logic [HASH_W-1:0] h3_q [4];

  // First multiply: only two distinct x corners exist.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 2; i++) begin
        a1_q[i]  <= HASH_W'(ux_i[i] * mult_a_i);
        uy1_q[i] <= uy_i[i];
      end
    end
  end

  // Second mix and multiply, corner k has x bit k[0] and y bit k[1].
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        a2_q[k] <= a1_q[k % 2];
        b2_q[k] <= HASH_W'((uy1_q[k / 2] ^ rot16(a1_q[k % 2])) * mult_b_i);
      end
    end
  end

  // Final mix and multiply.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        h3_q[k] <= HASH_W'((a2_q[k] ^ rot16(b2_q[k])) * mult_c_i);
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      angle_o[k] = h3_q[k][HASH_W-1 -: ANGLE_BITS];
    end
  end

endmodule

### rtl/pnz_grad_dot.sv
// Gradient lookup and corner dot products, three register stages.
module pnz_grad_dot (
  input  logic            clk_i,
  input  logic            en_i,
  input  pnz_pkg::angle_t angle_i [4],
  input  pnz_pkg::frac_t  fx_i,
  input  pnz_pkg::frac_t  fy_i,
  output pnz_pkg::dot_t   dot_o [4]
);
  import pnz_pkg::*;

  localparam ofs_t ONE = ofs_t'(1) <<< COORD_FRAC_BITS;
  localparam logic signed [2*OFS_W:0] ROUND =
    (2*OFS_W+1)'(1) <<< (COORD_FRAC_BITS - 1);

  grad_t gx_d [4];
  grad_t gy_d [4];
  grad_t gx_q [4];
  grad_t gy_q [4];
  ofs_t  dx_q [4];
  ofs_t  dy_q [4];
  logic signed [2*OFS_W-1:0] px_q [4];
  logic signed [2*OFS_W-1:0] py_q [4];
  dot_t  dot_q [4];

  // Quadrant table read and rotation into the full circle.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      logic [2*GRAD_W-1:0] ent;
      grad_t c, s;
      ent = GRAD_TBL[angle_i[k][QUAD_BITS-1:0]];
      c = ent[2*GRAD_W-1:GRAD_W];
      s = ent[GRAD_W-1:0];
      case (quad_e'(angle_i[k][ANGLE_BITS-1 -: 2]))
        QUAD_0:  begin gx_d[k] = c;  gy_d[k] = s;  end
        QUAD_1:  begin gx_d[k] = -s; gy_d[k] = c;  end
        QUAD_2:  begin gx_d[k] = -c; gy_d[k] = -s; end
        default: begin gx_d[k] = s;  gy_d[k] = -c; end
      endcase
    end
  end

  // Gradients and corner offsets.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        gx_q[k] <= gx_d[k];
        gy_q[k] <= gy_d[k];
        dx_q[k] <= (k % 2 == 1) ? ofs_t'(fx_i) - ONE : ofs_t'(fx_i);
        dy_q[k] <= (k / 2 == 1) ? ofs_t'(fy_i) - ONE : ofs_t'(fy_i);
      end
    end
  end

  // Component products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        px_q[k] <= gx_q[k] * dx_q[k];
        py_q[k] <= gy_q[k] * dy_q[k];
      end
    end
  end

  // Sum, round and scale to Q14.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        logic signed [2*OFS_W:0] sum;
        sum = px_q[k] + py_q[k] + ROUND;
        dot_q[k] <= DOT_W'(sum >>> COORD_FRAC_BITS);
      end
    end
  end

  assign dot_o = dot_q;

endmodule

### rtl/pnz_fade.sv
// Quintic fade weight pipeline, four register stages, result in Q16.
module pnz_fade (
  input  logic           clk_i,
  input  logic           en_i,
  input  pnz_pkg::frac_t frac_i,
  output pnz_pkg::wgt_t  w_o
);
  import pnz_pkg::*;

  logic [15:0]        s_d;
  logic [15:0]        s1_q;
  logic [31:0]        ss_q;
  logic signed [23:0] t0_q;
  logic signed [47:0] st_q;
  logic [31:0]        u1_q;
  logic signed [23:0] t_q;
  logic [15:0]        u_q;
  wgt_t               w_q;
  logic signed [47:0] prod;

  assign s_d = frac_to_q16(frac_i);

  // Square and the linear term 6s - 15.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s_d;
      ss_q <= s_d * s_d;
      t0_q <= $signed({8'b0, s_d}) * 24'sd6 - 24'sd983040;
    end
  end

  // s * t and the cube.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q <= $signed({1'b0, s1_q}) * t0_q;
      u1_q <= ss_q[31:16] * s1_q;
    end
  end

  // Quadratic factor plus ten, and the cube in Q16.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= 24'((st_q >>> 16) + 48'sd655360);
      u_q <= u1_q[31:16];
    end
  end

  // Final weight.
  assign prod = $signed({1'b0, u_q}) * t_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_q <= WGT_W'(prod >>> 16);
    end
  end

  assign w_o = w_q;

endmodule

### rtl/perlin_noise_2d_eval.sv
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is empty or being taken, so a stall holds every stage in place.
// The depth is set by the three chained hash multiplies, the gradient dot
// products and the blends along x and y. Reset clears all valid bits and loads
// the hash multipliers with their default values.
module perlin_noise_2d_eval (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pnz_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [pnz_pkg::HASH_W-1:0]    cfg_wdata_i,
  pnz_in_if.sink                        in_if,
  pnz_out_if.source                     out_if
);
  import pnz_pkg::*;

  localparam int LAST = 10;
  localparam int SUM_W = DOT_W + 3;

  logic              en;
  logic [LAST:0]     v_q;
  logic [HASH_W-1:0] mult_a_q, mult_b_q, mult_c_q;

  logic signed [31:0] x_q, y_q;
  logic signed [31:0] ix, iy;
  logic [HASH_W-1:0]  ux [2];
  logic [HASH_W-1:0]  uy [2];
  frac_t              fx, fy;
  frac_t              fx_q [3];
  frac_t              fy_q [3];
  angle_t             angle [4];
  dot_t               dot [4];
  wgt_t               wx, wy;
  wgt_t               wx_q [2];
  wgt_t               wy_q [4];

  dot_t                    d00_q, d01_q;
  logic signed [39:0]      mt_q, mb_q;
  logic signed [DOT_W:0]   top_q, bot_q, top9_q;
  logic signed [39:0]      my_q;
  logic signed [OUT_W-1:0] out_q;
  logic signed [DOT_W:0]   dtop, dbot;
  logic signed [DOT_W+1:0] dy;
  logic signed [SUM_W-1:0] vsum;
  logic signed [OUT_W-1:0] vsat;

  // Pipeline advances when the output register is empty or its result is being taken.
  assign en          = !v_q[LAST] || out_if.ready;
  assign in_if.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], in_if.valid};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mult_a_q <= MULT_A_RESET;
      mult_b_q <= MULT_B_RESET;
      mult_c_q <= MULT_C_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MULT_A: mult_a_q <= cfg_wdata_i;
        CFG_MULT_B: mult_b_q <= cfg_wdata_i;
        CFG_MULT_C: mult_c_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i) begin
    if (en) begin
      x_q <= in_if.x_coord;
      y_q <= in_if.y_coord;
    end
  end

  // Lattice cell and fraction; corners wrap as 32-bit two's complement.
  assign ix    = x_q >>> COORD_FRAC_BITS;
  assign iy    = y_q >>> COORD_FRAC_BITS;
  assign ux[0] = ix;
  assign ux[1] = ix + 32'sd1;
  assign uy[0] = iy;
  assign uy[1] = iy + 32'sd1;
  assign fx    = x_q[COORD_FRAC_BITS-1:0];
  assign fy    = y_q[COORD_FRAC_BITS-1:0];

  pnz_hash u_hash (
    .clk_i    (clk_i),
    .en_i     (en),
    .mult_a_i (mult_a_q),
    .mult_b_i (mult_b_q),
    .mult_c_i (mult_c_q),
    .ux_i     (ux),
    .uy_i     (uy),
    .angle_o  (angle)
  );

  // Fractions follow the hash stages.
  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q[0] <= fx;
      fy_q[0] <= fy;
      for (int i = 1; i < 3; i++) begin
        fx_q[i] <= fx_q[i-1];
        fy_q[i] <= fy_q[i-1];
      end
    end
  end

  pnz_grad_dot u_grad_dot (
    .clk_i   (clk_i),
    .en_i    (en),
    .angle_i (angle),
    .fx_i    (fx_q[2]),
    .fy_i    (fy_q[2]),
    .dot_o   (dot)
  );

  pnz_fade u_fade_x (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (fx),
    .w_o    (wx)
  );

  pnz_fade u_fade_y (
    .clk_i  (clk_i),
    .en_i   (en),
    .frac_i (fy),
    .w_o    (wy)
  );

  // Weights wait for the dot products and the first blend.
  always_ff @(posedge clk_i) begin
    if (en) begin
      wx_q[0] <= wx;
      wx_q[1] <= wx_q[0];
      wy_q[0] <= wy;
      for (int i = 1; i < 4; i++) begin
        wy_q[i] <= wy_q[i-1];
      end
    end
  end

  // Blend along x: products, then sums.
  assign dtop = dot[1] - dot[0];
  assign dbot = dot[3] - dot[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d00_q <= dot[0];
      d01_q <= dot[2];
      mt_q  <= wx_q[1] * dtop;
      mb_q  <= wx_q[1] * dbot;
      top_q <= (DOT_W+1)'(d00_q + (mt_q >>> 16));
      bot_q <= (DOT_W+1)'(d01_q + (mb_q >>> 16));
    end
  end

  // Blend along y.
  assign dy = bot_q - top_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      top9_q <= top_q;
      my_q   <= wy_q[3] * dy;
    end
  end

  // Final sum, scale and saturate into the output register.
  always_comb begin
    vsum = SUM_W'(top9_q + (my_q >>> 16)) >>> (14 - OUT_FRAC_BITS);
    if (vsum > SUM_W'(32767)) vsat = 16'sh7fff;
    else if (vsum < -SUM_W'(32768)) vsat = 16'sh8000;
    else vsat = vsum[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= vsat;
    end
  end

  assign out_if.valid       = v_q[LAST];
  assign out_if.noise_value = out_q;

endmodule

### rtl/pnz_checker.sv
// Port-level checks of the noise evaluator and their binding to the top level.
module pnz_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] noise_value_i
);

  // A result that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item withdrawn while stalled");

  // A stalled result keeps its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(noise_value_i))
    else $error("stalled result item changed");

  // The input side only waits while a result is held back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without a held result");

  // An empty output stage always frees the pipeline.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("pipeline blocked with empty output stage");

endmodule

bind perlin_noise_2d_eval pnz_checker u_pnz_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_if.valid),
  .in_ready_i    (in_if.ready),
  .out_valid_i   (out_if.valid),
  .out_ready_i   (out_if.ready),
  .noise_value_i (out_if.noise_value)
);
